[design/mwsk_pkg.sv]
// Shared types, constants and the quarter-wave sine table builder for the
// mecanum wheel speed kinematics block. No dependencies.
package mwsk_pkg;

	// Table shape and trig precision
	localparam int SINE_TABLE_DEPTH   = 1024;
	localparam int TRIG_FRACTION_BITS = 16;

	// Field widths
	localparam int HEADING_W = 16;
	localparam int VEL_W     = 24;
	localparam int INV_R_W   = 24;
	localparam int HALF_BT_W = 16;
	localparam int WHEEL_W   = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;

	// Heading split: two quadrant bits, the rest is the in-quadrant phase
	localparam int PHASE_W = HEADING_W - 2;

	// Sine table geometry
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PIX_W = PHASE_W + IDX_W;
	localparam int TAB_W = TRIG_FRACTION_BITS + 1;
	localparam int SIN_W = TRIG_FRACTION_BITS + 2;

	// Datapath widths
	localparam int TP_W  = VEL_W + SIN_W;
	localparam int BS_W  = TP_W + 1;
	localparam int BV_W  = BS_W - TRIG_FRACTION_BITS;
	localparam int MP_W  = HALF_BT_W + 1 + VEL_W;
	localparam int M_W   = MP_W - 16;
	localparam int SUM_W = BV_W + 1;
	localparam int WP_W  = SUM_W + INV_R_W + 1;
	localparam int WR_W  = WP_W - 16;

	// Register reset values
	localparam logic [INV_R_W-1:0]   INV_RADIUS_RESET = INV_R_W'(1638400);
	localparam logic [HALF_BT_W-1:0] HALF_BT_RESET    = HALF_BT_W'(14746);

	// pi/2 in Q30 for the table builder
	localparam longint unsigned HALF_PI_Q30 = 64'h6487ED51;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INV_RADIUS = 1'b0,
		CFG_HALF_BASE  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [HEADING_W-1:0]    heading;
		logic signed [VEL_W-1:0] velocity_a;
		logic signed [VEL_W-1:0] velocity_b;
		logic signed [VEL_W-1:0] yaw_rate;
	} pose_t;

	typedef struct packed {
		logic signed [WHEEL_W-1:0] wheel_front_left;
		logic signed [WHEEL_W-1:0] wheel_front_right;
		logic signed [WHEEL_W-1:0] wheel_back_left;
		logic signed [WHEEL_W-1:0] wheel_back_right;
		logic                      saturated;
	} rates_t;

	typedef logic [TAB_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

	// Quarter-wave sine by Taylor series in Q30, rounded to the trig fraction
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t       tab;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		int              i;
		for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x = (HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			// Alternating odd terms, each derived from the previous one
			term = ((term * x2) >> 30) / 6;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 20;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 42;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 72;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 110;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 156;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 210;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 272;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 342;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 420;
			sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 506;
			sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 600;
			sum = sum + longint'(term);
			if (sum < 0) begin
				sum = 0;
			end
			if (sum > (longint'(1) << 30)) begin
				sum = longint'(1) << 30;
			end
			sum = (sum + (longint'(1) << (29 - TRIG_FRACTION_BITS)))
				>>> (30 - TRIG_FRACTION_BITS);
			if (sum > (longint'(1) << TRIG_FRACTION_BITS)) begin
				sum = longint'(1) << TRIG_FRACTION_BITS;
			end
			tab[i] = TAB_W'(sum);
		end
		return tab;
	endfunction

	// Map the in-quadrant phase onto the nearest table index, capped at the depth
	function automatic logic [IDX_W-1:0] sine_index(input logic [PHASE_W-1:0] phase);
		logic [PIX_W-1:0] t;
		t = PIX_W'(phase) * PIX_W'(SINE_TABLE_DEPTH) + PIX_W'(1 << (PHASE_W - 1));
		t = t >> PHASE_W;
		if (t > PIX_W'(SINE_TABLE_DEPTH)) begin
			t = PIX_W'(SINE_TABLE_DEPTH);
		end
		return IDX_W'(t);
	endfunction

endpackage

[design/mecanum_wheel_speed_kinematics.sv]
// Top level of the mecanum wheel speed kinematics pipeline.
// Depends on mwsk_pkg for types, widths and the sine table builder.
//
// Turns a pose sample (heading, world velocity, yaw rate) into four wheel
// angular rates in Q16.16 with saturation and a clip flag. The pipeline has
// seven register stages and takes one sample per clock unless the output
// stalls with every stage full; a result moves through the stage registers
// in order and is presented from the last of them.
// Stages: table index and yaw product, dual-read sine ROM (sine and cosine
// read mirrored indexes), body-frame products, body velocities, wheel sums,
// inverse-radius products, round and clamp. Empty stages close up under an
// output stall, so the block keeps taking samples until every stage is full.
// The sine ROM holds SINE_TABLE_DEPTH+1 constant entries. Write the two
// configuration registers only while no transaction is in flight.
module mecanum_wheel_speed_kinematics (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pose_valid,
	output logic                                 pose_stall,
	input  mwsk_pkg::pose_t                      pose,
	output logic                                 rates_valid,
	input  logic                                 rates_stall,
	output mwsk_pkg::rates_t                     rates,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mwsk_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mwsk_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam mwsk_pkg::sine_tab_t SINE_ROM = mwsk_pkg::build_sine_tab();

	localparam logic signed [mwsk_pkg::BS_W-1:0] TRIG_HALF =
		mwsk_pkg::BS_W'(1) <<< (mwsk_pkg::TRIG_FRACTION_BITS - 1);
	localparam logic signed [mwsk_pkg::MP_W-1:0] MID_HALF =
		mwsk_pkg::MP_W'(1) <<< 15;
	localparam logic signed [mwsk_pkg::WP_W-1:0] WHEEL_HALF =
		mwsk_pkg::WP_W'(1) <<< 15;
	localparam logic signed [mwsk_pkg::WHEEL_W-1:0] WHEEL_MAX =
		{1'b0, {(mwsk_pkg::WHEEL_W - 1){1'b1}}};
	localparam logic signed [mwsk_pkg::WHEEL_W-1:0] WHEEL_MIN =
		{1'b1, {(mwsk_pkg::WHEEL_W - 1){1'b0}}};

	// Configuration registers
	logic [mwsk_pkg::INV_R_W-1:0]   inv_radius_q;
	logic [mwsk_pkg::HALF_BT_W-1:0] half_base_q;

	// Stage enables
	logic en1, en2, en3, en4, en5, en6, en7;

	// Stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	// Stage 0 combinational: table index and yaw product
	logic [1:0]                          quad;
	logic [mwsk_pkg::IDX_W-1:0]          idx_fwd;
	logic [mwsk_pkg::IDX_W-1:0]          idx_rev;
	logic signed [mwsk_pkg::MP_W-1:0]    mid_prod;

	// Stage 1
	logic [mwsk_pkg::IDX_W-1:0]          sidx_s1;
	logic [mwsk_pkg::IDX_W-1:0]          cidx_s1;
	logic                                sneg_s1;
	logic                                cneg_s1;
	logic signed [mwsk_pkg::VEL_W-1:0]   va_s1;
	logic signed [mwsk_pkg::VEL_W-1:0]   vb_s1;
	logic signed [mwsk_pkg::MP_W-1:0]    mprod_s1;

	// Stage 2
	logic signed [mwsk_pkg::SIN_W-1:0]   sin_s2;
	logic signed [mwsk_pkg::SIN_W-1:0]   cos_s2;
	logic signed [mwsk_pkg::VEL_W-1:0]   va_s2;
	logic signed [mwsk_pkg::VEL_W-1:0]   vb_s2;
	logic signed [mwsk_pkg::M_W-1:0]     m_s2;
	logic signed [mwsk_pkg::MP_W-1:0]    mid_round;
	logic [mwsk_pkg::TAB_W-1:0]          sin_raw;
	logic [mwsk_pkg::TAB_W-1:0]          cos_raw;

	// Stage 3
	logic signed [mwsk_pkg::TP_W-1:0]    p_bc_s3;
	logic signed [mwsk_pkg::TP_W-1:0]    p_as_s3;
	logic signed [mwsk_pkg::TP_W-1:0]    p_ac_s3;
	logic signed [mwsk_pkg::TP_W-1:0]    p_bs_s3;
	logic signed [mwsk_pkg::M_W-1:0]     m_s3;

	// Stage 4
	logic signed [mwsk_pkg::BS_W-1:0]    bvx_full;
	logic signed [mwsk_pkg::BS_W-1:0]    bvy_full;
	logic signed [mwsk_pkg::BV_W-1:0]    bvx_s4;
	logic signed [mwsk_pkg::BV_W-1:0]    bvy_s4;
	logic signed [mwsk_pkg::M_W-1:0]     m_s4;

	// Stage 5..7, one lane per wheel: FL, FR, BL, BR
	logic signed [mwsk_pkg::SUM_W-1:0]   bvx_e;
	logic signed [mwsk_pkg::SUM_W-1:0]   bvy_e;
	logic signed [mwsk_pkg::SUM_W-1:0]   m_e;
	logic signed [mwsk_pkg::SUM_W-1:0]   sum_s5 [4];
	logic signed [mwsk_pkg::WP_W-1:0]    wprod_s6 [4];
	logic signed [mwsk_pkg::WR_W-1:0]    wround [4];
	logic [3:0]                          clip;
	logic signed [mwsk_pkg::WHEEL_W-1:0] wclamp [4];
	mwsk_pkg::rates_t                    rates_s7;

	// Configuration writes, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_radius_q <= mwsk_pkg::INV_RADIUS_RESET;
			half_base_q  <= mwsk_pkg::HALF_BT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (mwsk_pkg::cfg_reg_t'(cfg_index))
				mwsk_pkg::CFG_INV_RADIUS: inv_radius_q <= cfg_data[mwsk_pkg::INV_R_W-1:0];
				mwsk_pkg::CFG_HALF_BASE:  half_base_q  <= cfg_data[mwsk_pkg::HALF_BT_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage advances when it is empty or the next one advances
	assign en7 = !v_s7 || !rates_stall;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pose_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pose_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// Stage 1: sine and cosine indexes from one table index, swapped in odd quadrants
	assign quad     = pose.heading[mwsk_pkg::HEADING_W-1 -: 2];
	assign idx_fwd  = mwsk_pkg::sine_index(pose.heading[mwsk_pkg::PHASE_W-1:0]);
	assign idx_rev  = mwsk_pkg::IDX_W'(mwsk_pkg::SINE_TABLE_DEPTH) - idx_fwd;
	assign mid_prod = $signed({1'b0, half_base_q}) * pose.yaw_rate;

	always_ff @(posedge clk) begin
		if (en1) begin
			sidx_s1  <= quad[0] ? idx_rev : idx_fwd;
			cidx_s1  <= quad[0] ? idx_fwd : idx_rev;
			sneg_s1  <= quad[1];
			cneg_s1  <= quad[1] ^ quad[0];
			va_s1    <= pose.velocity_a;
			vb_s1    <= pose.velocity_b;
			mprod_s1 <= mid_prod;
		end
	end

	// Stage 2: two-port ROM read with quadrant sign, round the yaw term
	assign sin_raw   = SINE_ROM[sidx_s1];
	assign cos_raw   = SINE_ROM[cidx_s1];
	assign mid_round = (mprod_s1 + MID_HALF) >>> 16;

	always_ff @(posedge clk) begin
		if (en2) begin
			sin_s2 <= sneg_s1 ? -$signed({1'b0, sin_raw}) : $signed({1'b0, sin_raw});
			cos_s2 <= cneg_s1 ? -$signed({1'b0, cos_raw}) : $signed({1'b0, cos_raw});
			va_s2  <= va_s1;
			vb_s2  <= vb_s1;
			m_s2   <= mid_round[mwsk_pkg::M_W-1:0];
		end
	end

	// Stage 3: rotation products
	always_ff @(posedge clk) begin
		if (en3) begin
			p_bc_s3 <= vb_s2 * cos_s2;
			p_as_s3 <= va_s2 * sin_s2;
			p_ac_s3 <= va_s2 * cos_s2;
			p_bs_s3 <= vb_s2 * sin_s2;
			m_s3    <= m_s2;
		end
	end

	// Stage 4: body-frame velocities, rounded to Q16
	assign bvx_full = mwsk_pkg::BS_W'(p_bc_s3) - mwsk_pkg::BS_W'(p_as_s3) + TRIG_HALF;
	assign bvy_full = mwsk_pkg::BS_W'(p_ac_s3) + mwsk_pkg::BS_W'(p_bs_s3) + TRIG_HALF;

	always_ff @(posedge clk) begin
		if (en4) begin
			bvx_s4 <= mwsk_pkg::BV_W'(bvx_full >>> mwsk_pkg::TRIG_FRACTION_BITS);
			bvy_s4 <= mwsk_pkg::BV_W'(bvy_full >>> mwsk_pkg::TRIG_FRACTION_BITS);
			m_s4   <= m_s3;
		end
	end

	// Stage 5: wheel mixing
	assign bvx_e = mwsk_pkg::SUM_W'(bvx_s4);
	assign bvy_e = mwsk_pkg::SUM_W'(bvy_s4);
	assign m_e   = mwsk_pkg::SUM_W'(m_s4);

	always_ff @(posedge clk) begin
		if (en5) begin
			sum_s5[0] <= bvy_e - bvx_e - m_e;
			sum_s5[1] <= bvy_e + bvx_e + m_e;
			sum_s5[2] <= bvy_e + bvx_e - m_e;
			sum_s5[3] <= bvy_e - bvx_e + m_e;
		end
	end

	// Stage 6: scale by inverse wheel radius
	always_ff @(posedge clk) begin
		if (en6) begin
			for (int j = 0; j < 4; j++) begin
				wprod_s6[j] <= sum_s5[j] * $signed({1'b0, inv_radius_q});
			end
		end
	end

	// Stage 7: round to Q16 and clamp to the 32-bit range
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			wround[j] = mwsk_pkg::WR_W'((wprod_s6[j] + WHEEL_HALF) >>> 16);
			clip[j] = !((&wround[j][mwsk_pkg::WR_W-1:mwsk_pkg::WHEEL_W-1]) ||
				(~|wround[j][mwsk_pkg::WR_W-1:mwsk_pkg::WHEEL_W-1]));
			if (clip[j]) begin
				wclamp[j] = wround[j][mwsk_pkg::WR_W-1] ? WHEEL_MIN : WHEEL_MAX;
			end else begin
				wclamp[j] = wround[j][mwsk_pkg::WHEEL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			rates_s7.wheel_front_left  <= wclamp[0];
			rates_s7.wheel_front_right <= wclamp[1];
			rates_s7.wheel_back_left   <= wclamp[2];
			rates_s7.wheel_back_right  <= wclamp[3];
			rates_s7.saturated         <= |clip;
		end
	end

	assign rates_valid = v_s7;
	assign rates       = rates_s7;

`ifndef SYNTHESIS
	// A clip flag implies some wheel sits at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		rates_valid && rates.saturated |->
			rates.wheel_front_left == WHEEL_MAX || rates.wheel_front_left == WHEEL_MIN ||
			rates.wheel_front_right == WHEEL_MAX || rates.wheel_front_right == WHEEL_MIN ||
			rates.wheel_back_left == WHEEL_MAX || rates.wheel_back_left == WHEEL_MIN ||
			rates.wheel_back_right == WHEEL_MAX || rates.wheel_back_right == WHEEL_MIN)
		else $error("saturated set with no wheel at a rail");

	// An empty entry stage never back-pressures the input
	a_entry_open: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !pose_stall)
		else $error("input stalled with entry stage empty");

	// A transaction in the last stage before output moves out when allowed
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && en7 |=> rates_valid)
		else $error("transaction lost between last stages");
`endif

endmodule
